### src/tss_pkg.sv
// Package for the shared-store stack block: field widths, command and
// status codes, and the control types passed between the boundary unit and cells.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

    localparam int CAPACITY_DEF    = 32;
    localparam int STACK_COUNT_DEF = 3;

    localparam int VALUE_W  = 32;
    localparam int SEL_W    = 2;
    localparam int STATUS_W = 2;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // operation that actually changes the store this cycle
    typedef struct packed {
        logic push;
        logic pop;
    } t_op;

endpackage

`default_nettype wire

### src/tss_if.sv
// Valid/ready channel interfaces for command words and result words.
// Depends on tss_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tss_in_if
    import tss_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic [SEL_W-1:0]          stack_select;
    logic signed [VALUE_W-1:0] push_value;

    modport source (output valid, command, stack_select, push_value, input ready);
    modport sink   (input valid, command, stack_select, push_value, output ready);
endinterface

interface tss_out_if
    import tss_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] pop_value;
    logic [STATUS_W-1:0]       status;

    modport source (output valid, pop_value, status, input ready);
    modport sink   (input valid, pop_value, status, output ready);
endinterface

`default_nettype wire

### src/tss_cell.sv
// One cell of the packed store: holds a value and shifts it to or from its
// neighbours when an entry is inserted or removed below it. Depends on tss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tss_cell
    import tss_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int IDX_W = 6
) (
    input  wire logic                      i_clk,
    input  wire t_op                       i_op,
    input  wire logic [IDX_W-1:0]          i_pos,
    input  wire logic signed [VALUE_W-1:0] i_push_value,
    input  wire logic signed [VALUE_W-1:0] i_below,
    input  wire logic signed [VALUE_W-1:0] i_above,
    output logic signed [VALUE_W-1:0]      o_value
);

    localparam logic [IDX_W:0] K_IDX  = (IDX_W+1)'(IDX);
    localparam logic [IDX_W:0] K_IDX1 = (IDX_W+1)'(IDX + 1);

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;
    logic [IDX_W:0]            w_pos;

    assign w_pos = {1'b0, i_pos};

    always_comb begin
        n_value = r_value;
        if (i_op.push && K_IDX == w_pos) begin
            n_value = i_push_value;
        end else if (i_op.push && K_IDX > w_pos) begin
            n_value = i_below;
        end else if (i_op.pop && K_IDX1 >= w_pos) begin
            // close the gap left by the removed top entry
            n_value = i_above;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

### src/tss_bound.sv
// Boundary unit: holds the stack boundaries and element count, decides
// push/pop outcome and moves boundaries. Depends on tss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tss_bound
    import tss_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int STACK_COUNT = STACK_COUNT_DEF,
    parameter int IDX_W       = $clog2(CAPACITY + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire logic             i_command,
    input  wire logic [SEL_W-1:0] i_stack_select,
    output t_op                   o_op,
    output logic [IDX_W-1:0]      o_pos,
    output logic [IDX_W-1:0]      o_count,
    output logic [STATUS_W-1:0]   o_status
);

    localparam int SW = $clog2(STACK_COUNT);
    localparam logic [IDX_W-1:0] K_CAP = IDX_W'(CAPACITY);

    // entry j is the upper end of stack j; the last entry is the element count
    logic [IDX_W-1:0] r_bnd [STACK_COUNT];
    logic [IDX_W-1:0] n_bnd [STACK_COUNT];
    logic [SW-1:0]    w_sel;
    logic [IDX_W-1:0] w_lo;
    logic [IDX_W-1:0] w_hi;
    logic             w_full;
    logic             w_empty;

    always_comb begin
        if (int'(i_stack_select) >= STACK_COUNT) begin
            w_sel = SW'(STACK_COUNT - 1);
        end else begin
            w_sel = SW'(i_stack_select);
        end
    end

    assign w_hi    = r_bnd[w_sel];
    assign w_lo    = (w_sel == '0) ? '0 : r_bnd[w_sel - SW'(1)];
    assign w_full  = (r_bnd[STACK_COUNT-1] >= K_CAP);
    assign w_empty = (w_hi <= w_lo);

    assign o_op.push = i_fire && (i_command == CMD_PUSH) && !w_full;
    assign o_op.pop  = i_fire && (i_command == CMD_POP) && !w_empty;
    assign o_pos     = w_hi;
    assign o_count   = r_bnd[STACK_COUNT-1];

    always_comb begin
        if (i_command == CMD_PUSH && w_full) begin
            o_status = ST_FULL;
        end else if (i_command == CMD_POP && w_empty) begin
            o_status = ST_EMPTY;
        end else begin
            o_status = ST_DONE;
        end
    end

    always_comb begin
        for (int j = 0; j < STACK_COUNT; j++) begin
            n_bnd[j] = r_bnd[j];
            if (j >= int'(w_sel)) begin
                if (o_op.push) begin
                    n_bnd[j] = r_bnd[j] + IDX_W'(1);
                end else if (o_op.pop) begin
                    n_bnd[j] = r_bnd[j] - IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < STACK_COUNT; j++) begin
                r_bnd[j] <= '0;
            end
        end else begin
            r_bnd <= n_bnd;
        end
    end

endmodule

`default_nettype wire

### src/three_stacks_shared_store.sv
// Several LIFO stacks packed in order into one shared store.
// Channels: i_in carries command words (command, stack_select, push_value);
// o_out carries one result word (pop_value, status) per command word.
// A push inserts at the top of the chosen stack, a pop removes its newest
// value; a row of cells shifts every later entry up or down in the same cycle.
// A stack_select beyond the last stack addresses the last stack.
// Status: done, store full on a refused push, stack empty on a refused pop;
// pop_value is zero unless a pop succeeds.
// The result word is registered and valid in the cycle after the command is taken.
// Throughput: one command per cycle while the receiver takes the result words; the cell
// row and the boundary update both complete in the cycle the command is taken.
// The input is taken whenever the output register is empty or being drained,
// so a stalled receiver holds the result word and blocks further commands.
// Synchronous active-low reset empties all stacks and the output register;
// cell contents are not reset.
// Depends on tss_pkg, tss_if, tss_cell and tss_bound.
`timescale 1ns / 1ps
`default_nettype none

module three_stacks_shared_store
    import tss_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int STACK_COUNT = STACK_COUNT_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tss_in_if.sink    i_in,
    tss_out_if.source o_out
);

    localparam int IDX_W = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);

    logic                      w_fire;
    t_op                       w_op;
    logic [IDX_W-1:0]          w_pos;
    logic [IDX_W-1:0]          w_count;
    logic [STATUS_W-1:0]       w_status;
    logic [IDX_W-1:0]          w_top;
    logic signed [VALUE_W-1:0] w_cell [CAPACITY];
    logic signed [VALUE_W-1:0] w_pop_value;

    logic                      r_valid;
    logic signed [VALUE_W-1:0] r_pop_value;
    logic [STATUS_W-1:0]       r_status;

    assign i_in.ready = !r_valid || o_out.ready;
    assign w_fire     = i_in.valid && i_in.ready;

    tss_bound #(
        .CAPACITY    (CAPACITY),
        .STACK_COUNT (STACK_COUNT),
        .IDX_W       (IDX_W)
    ) u_bound (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_command      (i_in.command),
        .i_stack_select (i_in.stack_select),
        .o_op           (w_op),
        .o_pos          (w_pos),
        .o_count        (w_count),
        .o_status       (w_status)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VALUE_W-1:0] w_below;
        logic signed [VALUE_W-1:0] w_above;

        if (g == 0) begin : g_first
            assign w_below = '0;
        end else begin : g_mid_lo
            assign w_below = w_cell[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_above = w_cell[g];
        end else begin : g_mid_hi
            assign w_above = w_cell[g+1];
        end

        tss_cell #(
            .IDX   (g),
            .IDX_W (IDX_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_op         (w_op),
            .i_pos        (w_pos),
            .i_push_value (i_in.push_value),
            .i_below      (w_below),
            .i_above      (w_above),
            .o_value      (w_cell[g])
        );
    end

    // newest entry of the addressed stack sits just below its upper boundary
    assign w_top       = w_pos - IDX_W'(1);
    assign w_pop_value = w_op.pop ? w_cell[w_top[AW-1:0]] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_fire) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_pop_value <= w_pop_value;
            r_status    <= w_status;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.pop_value = r_pop_value;
    assign o_out.status    = r_status;

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(w_count) <= CAPACITY)
        else $error("element count beyond capacity");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_op.push |=> w_count == $past(w_count) + IDX_W'(1))
        else $error("push did not grow the element count");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_op.pop |=> w_count == $past(w_count) - IDX_W'(1))
        else $error("pop did not shrink the element count");

    a_refused_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_status != ST_DONE) |=> (o_out.pop_value == '0 && $stable(w_count)))
        else $error("refused command changed state or returned data");

endmodule

`default_nettype wire
